// ===== sv/twcp_pkg.sv =====
// Shared types, register map and reset values for the coincidence pair builder.
`timescale 1ns / 1ps

package twcp_pkg;

  localparam int MAX_HITS_DEF = 8;

  localparam int TIME_W   = 48;
  localparam int ENERGY_W = 15;
  localparam int TICKS_W  = 16;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICKS_W-1:0]  WINDOW_TICKS_RST   = 16'd100;
  localparam logic                VETO_ENABLE_RST    = 1'b1;
  localparam logic [ENERGY_W-1:0] VETO_CENTER_RST    = 15'd8176;
  localparam logic [ENERGY_W-1:0] VETO_HALFWIDTH_RST = 15'd48;

  typedef enum logic [1:0] {
    REG_WINDOW_TICKS   = 2'd0,
    REG_VETO_ENABLE    = 2'd1,
    REG_VETO_CENTER    = 2'd2,
    REG_VETO_HALFWIDTH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TICKS_W-1:0]  window_ticks;
    logic                veto_enable;
    logic [ENERGY_W-1:0] veto_center;
    logic [ENERGY_W-1:0] veto_halfwidth;
  } twcp_cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap_item;   // latch the accepted input transaction
    logic open_win;   // start a window with the latched hit in slot 0
    logic add_hit;    // append latched hit, or flag overflow
    logic close_win;  // empty the buffer, no window open
    logic scan_init;  // reset pair indexes and pending pair
    logic scan_step;  // advance to the next (a, b) pair
    logic hold_pair;  // current pair becomes the pending pair
    logic emit_pend;  // move pending pair into the output register
    logic emit_last;  // the pair emitted now closes the window
  } twcp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic flush;
    logic win_open;
    logic later;      // latched hit lies past the window end
    logic cnt_lt2;    // fewer than two buffered hits
    logic pair_ok;    // current pair is distinct and not vetoed
    logic pend_v;
    logic out_stall;  // output register full and not taken
    logic scan_last;
  } twcp_sts_t;

endpackage

// ===== sv/twcp_regs.sv =====
// APB-style configuration register file.
`timescale 1ns / 1ps

module twcp_regs
  import twcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output twcp_cfg_t             cfg
);

  twcp_cfg_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks   <= WINDOW_TICKS_RST;
      cfg_r.veto_enable    <= VETO_ENABLE_RST;
      cfg_r.veto_center    <= VETO_CENTER_RST;
      cfg_r.veto_halfwidth <= VETO_HALFWIDTH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW_TICKS:   cfg_r.window_ticks   <= pwdata[TICKS_W-1:0];
        REG_VETO_ENABLE:    cfg_r.veto_enable    <= pwdata[0];
        REG_VETO_CENTER:    cfg_r.veto_center    <= pwdata[ENERGY_W-1:0];
        REG_VETO_HALFWIDTH: cfg_r.veto_halfwidth <= pwdata[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_TICKS:   prdata = {{(CFG_DATA_W-TICKS_W){1'b0}}, cfg_r.window_ticks};
      REG_VETO_ENABLE:    prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.veto_enable};
      REG_VETO_CENTER:    prdata = {{(CFG_DATA_W-ENERGY_W){1'b0}}, cfg_r.veto_center};
      REG_VETO_HALFWIDTH: prdata = {{(CFG_DATA_W-ENERGY_W){1'b0}}, cfg_r.veto_halfwidth};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== sv/twcp_dp.sv =====
// Datapath: hit latch, window state, energy buffer, pair scan and output register.
`timescale 1ns / 1ps

module twcp_dp
  import twcp_pkg::*;
#(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twcp_cfg_t             cfg,
  input  twcp_cmd_t             cmd,
  output twcp_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W = $clog2(MAX_HITS);
  localparam int CNT_W = $clog2(MAX_HITS + 1);

  // latched input transaction
  logic [TIME_W-1:0]   t_r;
  logic [ENERGY_W-1:0] e_r;
  logic                flush_r;

  // window state
  logic [TIME_W-1:0] start_r;
  logic              open_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;

  logic [ENERGY_W-1:0] ebuf_r [MAX_HITS];
  logic [ENERGY_W-1:0] rd_a_r, rd_b_r;

  // pair scan
  logic [IDX_W-1:0]    a_r, b_r;
  logic [ENERGY_W-1:0] pend_first_r, pend_second_r;
  logic                pend_v_r;

  logic [ENERGY_W-1:0] out_first_r, out_second_r;
  logic                out_trunc_r, out_last_r, out_valid_r;

  logic [TIME_W:0]     win_end;
  logic                room;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    last_idx;
  logic                near_a, near_b;

  function automatic logic near_peak(input logic [ENERGY_W-1:0] e,
                                     input logic [ENERGY_W-1:0] c,
                                     input logic [ENERGY_W-1:0] h);
    logic [ENERGY_W-1:0] d;
    d = (e >= c) ? (e - c) : (c - e);
    return d < h;
  endfunction

  assign win_end  = {1'b0, start_r} + {{(TIME_W+1-TICKS_W){1'b0}}, cfg.window_ticks};
  assign room     = cnt_r < CNT_W'(MAX_HITS);
  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign near_a   = near_peak(rd_a_r, cfg.veto_center, cfg.veto_halfwidth);
  assign near_b   = near_peak(rd_b_r, cfg.veto_center, cfg.veto_halfwidth);

  assign wr_en   = cmd.open_win || (cmd.add_hit && room);
  assign wr_addr = cmd.open_win ? '0 : cnt_r[IDX_W-1:0];

  always_comb begin
    sts.flush     = flush_r;
    sts.win_open  = open_r;
    sts.later     = {1'b0, t_r} > win_end;
    sts.cnt_lt2   = cnt_r < CNT_W'(2);
    sts.pair_ok   = (a_r != b_r) && !(cfg.veto_enable && near_a && near_b);
    sts.pend_v    = pend_v_r;
    sts.out_stall = out_valid_r && !out_tready;
    sts.scan_last = (a_r == last_idx) && (b_r == last_idx);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      t_r     <= in_tdata[TIME_W-1:0];
      e_r     <= in_tdata[TIME_W +: ENERGY_W];
      flush_r <= in_tuser;
    end
    if (cmd.open_win) begin
      start_r <= t_r;
    end
    if (wr_en) begin
      ebuf_r[wr_addr] <= e_r;
    end
    rd_a_r <= ebuf_r[a_r];
    rd_b_r <= ebuf_r[b_r];
    if (cmd.scan_init) begin
      a_r <= '0;
      b_r <= '0;
    end else if (cmd.scan_step) begin
      if (b_r == last_idx) begin
        b_r <= '0;
        a_r <= a_r + IDX_W'(1);
      end else begin
        b_r <= b_r + IDX_W'(1);
      end
    end
    if (cmd.hold_pair) begin
      pend_first_r  <= rd_a_r;
      pend_second_r <= rd_b_r;
    end
    if (cmd.emit_pend) begin
      out_first_r  <= pend_first_r;
      out_second_r <= pend_second_r;
      out_trunc_r  <= ovf_r;
      out_last_r   <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.open_win) begin
        open_r <= 1'b1;
        cnt_r  <= CNT_W'(1);
        ovf_r  <= 1'b0;
      end else if (cmd.close_win) begin
        open_r <= 1'b0;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.add_hit) begin
        if (room) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan_init || cmd.emit_last) begin
        pend_v_r <= 1'b0;
      end else if (cmd.hold_pair) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.emit_pend) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*ENERGY_W){1'b0}}, out_second_r, out_first_r};
  assign out_tuser  = out_trunc_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/twcp_ctrl.sv =====
// Controller: sequences hit handling, window close pair scan and result hand-off.
`timescale 1ns / 1ps

module twcp_ctrl
  import twcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  twcp_sts_t sts,
  output twcp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RD,
    S_CHK,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r;

  assign in_tready = rdy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.cap_item = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.flush) begin
          if (sts.win_open && !sts.cnt_lt2) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_RD;
          end else begin
            cmd.close_win = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (!sts.win_open) begin
          cmd.open_win = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.later) begin
          if (sts.cnt_lt2) begin
            state_nxt = S_FIN;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_RD;
          end
        end else begin
          cmd.add_hit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      // buffer read for the current pair is in flight
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!(sts.pair_ok && sts.pend_v && sts.out_stall)) begin
          cmd.hold_pair = sts.pair_ok;
          cmd.emit_pend = sts.pair_ok && sts.pend_v;
          if (sts.scan_last) begin
            state_nxt = S_DRAIN;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      // the last kept pair goes out marked as last
      S_DRAIN: begin
        if (!sts.pend_v) begin
          state_nxt = S_FIN;
        end else if (!sts.out_stall) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.flush) begin
          cmd.close_win = 1'b1;
        end else begin
          cmd.open_win = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= (state_nxt == S_IDLE);
    end
  end

endmodule

// ===== sv/time_window_coincidence_pairs_unit.sv =====
// Top level of the time-window coincidence pair builder.
// Hits enter on the in_ stream (tdata: hit_time, hit_energy; tuser: flush) in
// time order. The first hit opens a coincidence window; a hit past
// window start + window_ticks closes it, and every ordered pair of distinct
// buffered hits comes out on the out_ stream (tdata: energy_first,
// energy_second; tuser: window_truncated; tlast: last pair of the window).
// Pairs with both energies near veto_center are dropped when the veto is on.
// A transaction with flush set closes the open window without opening another.
// A hit that does not close a window passes through the evaluate state, with
// in_tready low meanwhile. Closing a window with n buffered hits walks all
// n*n slot pairs through the two-port buffer read, each pair in a read and
// a check state, with the input blocked; one result register decouples the
// output. If out_tready stays low, the scan holds on the next kept pair while
// the input stays blocked. Synchronous reset closes any window and drops
// pending results; in_tready is registered and rises once reset is released.
// Registers are written through the cfg_ APB port (pready always high); the
// user must write them only while idle, which the block does not enforce.
`timescale 1ns / 1ps

module time_window_coincidence_pairs_unit
  import twcp_pkg::*;
#(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [47:0] hit_time, [62:48] hit_energy
  input  logic                  in_tuser,   // [0] flush
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [14:0] energy_first, [29:15] energy_second
  output logic                  out_tuser,  // [0] window_truncated
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  twcp_cfg_t cfg;
  twcp_cmd_t cmd;
  twcp_sts_t sts;

  twcp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  twcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  twcp_dp #(
    .MAX_HITS (MAX_HITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/time_window_coincidence_pairs_unit_test.sv =====
// Self-checking testbench for the coincidence pair builder: stream stimulus, pair scoreboard.
`timescale 1ns / 1ps

module time_window_coincidence_pairs_unit_test;
  import twcp_pkg::*;

  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASE_ITEMS  = 82;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_first;
    logic [ENERGY_W-1:0] energy_second;
    logic                truncated;
    logic                last;
  } pair_t;

  class coincidence_scoreboard;
    twcp_cfg_t           regs;
    logic [TIME_W-1:0]   window_start;
    logic                window_open;
    logic [ENERGY_W-1:0] energies[MAX_HITS_DEF];
    int                  hit_count;
    logic                overflow;
    pair_t               expected_pairs[$];
    int                  mismatches;

    function new();
      regs.window_ticks   = WINDOW_TICKS_RST;
      regs.veto_enable    = VETO_ENABLE_RST;
      regs.veto_center    = VETO_CENTER_RST;
      regs.veto_halfwidth = VETO_HALFWIDTH_RST;
      window_start = '0;
      window_open  = 1'b0;
      hit_count    = 0;
      overflow     = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WINDOW_TICKS:   regs.window_ticks   = value[TICKS_W-1:0];
        REG_VETO_ENABLE:    regs.veto_enable    = value[0];
        REG_VETO_CENTER:    regs.veto_center    = value[ENERGY_W-1:0];
        REG_VETO_HALFWIDTH: regs.veto_halfwidth = value[ENERGY_W-1:0];
        default: ;
      endcase
    endfunction

    function bit near_peak(logic [ENERGY_W-1:0] e);
      logic [ENERGY_W-1:0] spread;
      spread = (e >= regs.veto_center) ? e - regs.veto_center : regs.veto_center - e;
      return spread < regs.veto_halfwidth;
    endfunction

    function void emit_window_pairs();
      pair_t p;
      int    n_found;
      n_found = 0;
      for (int a = 0; a < hit_count; a++) begin
        for (int b = 0; b < hit_count; b++) begin
          if (a != b &&
              !(regs.veto_enable && near_peak(energies[a]) && near_peak(energies[b]))) begin
            p.energy_first  = energies[a];
            p.energy_second = energies[b];
            p.truncated     = overflow;
            p.last          = 1'b0;
            expected_pairs.insert(expected_pairs.size(), p);
            n_found++;
          end
        end
      end
      // the flag of a window with no pair is simply lost
      if (n_found > 0) expected_pairs[expected_pairs.size()-1].last = 1'b1;
      hit_count = 0;
      overflow  = 1'b0;
    endfunction

    function void store_hit(logic [ENERGY_W-1:0] e);
      if (hit_count < MAX_HITS_DEF) begin
        energies[hit_count] = e;
        hit_count++;
      end else begin
        overflow = 1'b1;
      end
    endfunction

    function void note_hit(logic [TIME_W-1:0] t, logic [ENERGY_W-1:0] e, logic flush);
      logic [TIME_W:0] window_end;
      logic [TIME_W:0] ticks_wide;
      ticks_wide = regs.window_ticks;
      window_end = {1'b0, window_start} + ticks_wide;
      if (flush) begin
        if (window_open) emit_window_pairs();
        window_open = 1'b0;
        hit_count   = 0;
        overflow    = 1'b0;
      end else if (!window_open) begin
        window_open  = 1'b1;
        window_start = t;
        hit_count    = 0;
        overflow     = 1'b0;
        store_hit(e);
      end else if ({1'b0, t} > window_end) begin
        emit_window_pairs();
        window_start = t;
        store_hit(e);
      end else begin
        // earlier times also land here and join the window
        store_hit(e);
      end
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected pair first=%0d second=%0d trunc=%0b last=%0b",
                   got.energy_first, got.energy_second, got.truncated, got.last);
        return;
      end
      want = expected_pairs.pop_front();
      if (got.energy_first !== want.energy_first || got.energy_second !== want.energy_second ||
          got.truncated !== want.truncated || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected first=%0d second=%0d trunc=%0b last=%0b, got %0d %0d %0b %0b",
                   want.energy_first, want.energy_second, want.truncated, want.last,
                   got.energy_first, got.energy_second, got.truncated, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [47:0] hit_time, [62:48] hit_energy
  logic                  in_tuser;   // [0] flush
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [14:0] energy_first, [29:15] energy_second
  logic                  out_tuser;  // [0] window_truncated
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  coincidence_scoreboard pairs_sb = new();
  int tx_calm_left = 0;
  int cycle_count = 0;

  time_window_coincidence_pairs_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Idle gap before each transaction, drawn at random, with occasional stretches of none.
  function automatic int draw_idle(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  // Bias a third of the energies toward the veto peak.
  function automatic logic [ENERGY_W-1:0] rand_energy(twcp_cfg_t c);
    int v;
    if ($urandom_range(0, 2) != 0) return ENERGY_W'($urandom);
    v = int'(c.veto_center) + int'($urandom_range(0, 2 * int'(c.veto_halfwidth) + 2))
        - int'(c.veto_halfwidth) - 1;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return ENERGY_W'(v);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pairs_sb.write_reg(idx, value);
  endtask

  task automatic send_item(input logic [TIME_W-1:0] t, input logic [ENERGY_W-1:0] e,
                           input logic flush);
    int gap;
    gap = draw_idle(tx_calm_left);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, e, t};
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pairs_sb.note_hit(t, e, flush);
  endtask

  // Drain every expected pair, then give a hit that closed nothing time to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pairs_sb.expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int    stall;
    int    calm_left;
    int    pairs_seen;
    pair_t got;
    calm_left  = 0;
    pairs_seen = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_idle(calm_left);
      // hold off long enough that the block backs up into in_tready
      if (pairs_seen % 500 == 200) stall = 400;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.energy_first  = out_tdata[ENERGY_W-1:0];
      got.energy_second = out_tdata[2*ENERGY_W-1:ENERGY_W];
      got.truncated     = out_tuser;
      got.last          = out_tlast;
      pairs_seen++;
      pairs_sb.check_pair(got);
    end
  end

  initial begin : stimulus
    twcp_cfg_t         settings[6];
    logic [TIME_W:0]   base;
    logic [TIME_W-1:0] t;
    int                n_hits;
    int                offset;
    int                sent;
    int                kind;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values.
    send_item(rand_time(), ENERGY_W'($urandom), 1'b1);  // flush with no window open
    send_item(48'd10, 15'd0, 1'b0);
    send_item(48'd110, 15'h7FFF, 1'b0);                 // exactly at the window end
    send_item(48'd110, 15'd8176, 1'b0);                 // same timestamp, on the peak
    send_item(48'd5, 15'd8223, 1'b0);                   // earlier than window start
    send_item(48'd110, 15'd8128, 1'b0);                 // distance equals half width
    send_item(48'd111, 15'd5, 1'b0);                    // closes the window
    repeat (8) send_item(48'd150, 15'd777, 1'b0);       // equal energies, one too many
    send_item(rand_time(), ENERGY_W'($urandom), 1'b1);
    send_item(48'd1000, 15'd1, 1'b0);
    send_item(48'd2000, 15'd8176, 1'b0);                // single-hit window gives nothing
    send_item(48'd2001, 15'd8180, 1'b0);
    send_item(48'd5000, 15'd3, 1'b0);                   // every pair vetoed
    send_item(rand_time(), ENERGY_W'($urandom), 1'b1);
    send_item(TIME_MAX - 48'd1, 15'd100, 1'b0);         // window end past 48 bits
    send_item(TIME_MAX, 15'd200, 1'b0);
    send_item(rand_time(), ENERGY_W'($urandom), 1'b1);
    wait_idle();

    settings[0] = '{WINDOW_TICKS_RST, 1'b1, VETO_CENTER_RST, VETO_HALFWIDTH_RST};
    settings[1] = '{16'd0, 1'b1, 15'd0, 15'h7FFF};
    settings[2] = '{16'hFFFF, 1'b0, 15'h7FFF, 15'd0};
    settings[3] = '{TICKS_W'($urandom_range(1, 40)), 1'b1, ENERGY_W'($urandom),
                    ENERGY_W'($urandom_range(0, 300))};
    settings[4] = '{TICKS_W'($urandom), 1'($urandom), ENERGY_W'($urandom),
                    ENERGY_W'($urandom_range(0, 2000))};
    settings[5] = '{16'd20, 1'b1, 15'h7FFF, 15'd1};

    foreach (settings[p]) begin
      write_reg(REG_WINDOW_TICKS, CFG_DATA_W'(settings[p].window_ticks));
      write_reg(REG_VETO_ENABLE, CFG_DATA_W'(settings[p].veto_enable));
      write_reg(REG_VETO_CENTER, CFG_DATA_W'(settings[p].veto_center));
      write_reg(REG_VETO_HALFWIDTH, CFG_DATA_W'(settings[p].veto_halfwidth));
      base = {1'b0, rand_time() >> 1};
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
          send_item(rand_time(), rand_energy(settings[p]), 1'b1);
          sent++;
        end else if (kind == 1) begin
          // stray hit anywhere in time
          send_item(rand_time(), rand_energy(settings[p]), 1'b0);
          sent++;
        end else begin
          base = base + settings[p].window_ticks + 1 + $urandom_range(0, 200);
          if (kind == 2 || base + settings[p].window_ticks > {1'b0, TIME_MAX}) begin
            send_item(rand_time(), rand_energy(settings[p]), 1'b1);
            sent++;
            base = {1'b0, rand_time() >> 1};
          end
          n_hits = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
          offset = 0;
          repeat (n_hits) begin
            t = base[TIME_W-1:0] + TIME_W'(offset);
            send_item(t, rand_energy(settings[p]), 1'b0);
            sent++;
            offset += $urandom_range(0, settings[p].window_ticks / 3 + 1);
            if (offset > int'(settings[p].window_ticks)) offset = int'(settings[p].window_ticks);
          end
        end
      end
      send_item(rand_time(), rand_energy(settings[p]), 1'b1);
      wait_idle();
    end

    if (pairs_sb.mismatches == 0 && pairs_sb.expected_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/twcp_pkg.sv
sv/twcp_regs.sv
sv/twcp_dp.sv
sv/twcp_ctrl.sv
sv/time_window_coincidence_pairs_unit.sv
tb/time_window_coincidence_pairs_unit_test.sv
